>>> rtl/cfr_pkg.sv
package cfr_pkg;

  localparam int unsigned PAYLOAD_DEPTH = 64;
  localparam int unsigned ADDR_W        = $clog2(PAYLOAD_DEPTH);
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned IDX_W         = 5;

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hFF;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'hFC;
  localparam logic [BYTE_W-1:0] CMD_LIMIT  = 8'hFF;
  localparam logic [BYTE_W-1:0] LEN_LIMIT  = 8'd50;

  localparam logic REC_PAIR   = 1'b0;
  localparam logic REC_REGION = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GOT_FF,
    ST_GOT_FC,
    ST_GOT_CMD,
    ST_PAYLOAD,
    ST_CHECKSUM,
    ST_READ,
    ST_SEND
  } cfr_state_e;

  typedef struct packed {
    logic sum_init;
    logic sum_add;
    logic len_load;
    logic pay_write;
    logic csum_save;
    logic rd_issue;
    logic idx_inc;
  } cfr_cmd_t;

  typedef struct packed {
    logic hdr_first;
    logic hdr_second;
    logic cmd_ok;
    logic len_ok;
    logic rem_nz;
    logic rem_one;
    logic sum_ok;
    logic rec_last;
  } cfr_sts_t;

endpackage

>>> rtl/cfr_if.sv
interface cfr_in_if;
  import cfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_out_if;
  import cfr_pkg::*;

  logic              valid;
  logic              ready;
  logic              record_kind;
  logic [IDX_W-1:0]  pair_index;
  logic [IDX_W-1:0]  pair_count;
  logic [BYTE_W-1:0] value_a;
  logic [BYTE_W-1:0] value_b;
  logic              last;

  modport source (output valid, output record_kind, output pair_index, output pair_count,
                  output value_a, output value_b, output last, input ready);
  modport sink   (input valid, input record_kind, input pair_index, input pair_count,
                  input value_a, input value_b, input last, output ready);
endinterface

>>> rtl/cfr_ctrl.sv
module cfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  input  logic              rec_ready_i,
  input  cfr_pkg::cfr_sts_t sts_i,
  output logic              rx_ready_o,
  output logic              rec_valid_o,
  output cfr_pkg::cfr_cmd_t cmd_o
);
  import cfr_pkg::*;

  cfr_state_e state_q, state_d;
  logic       rx_xfer;

  // byte intake pauses only while a record burst is read out
  assign rx_ready_o = (state_q != ST_READ) && (state_q != ST_SEND);
  assign rx_xfer    = rx_valid_i & rx_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (rx_xfer) state_d = sts_i.hdr_first ? ST_GOT_FF : ST_IDLE;
      end
      ST_GOT_FF: begin
        if (rx_xfer) state_d = sts_i.hdr_second ? ST_GOT_FC : ST_IDLE;
      end
      ST_GOT_FC: begin
        if (rx_xfer) state_d = sts_i.cmd_ok ? ST_GOT_CMD : ST_IDLE;
      end
      ST_GOT_CMD: begin
        if (rx_xfer) state_d = sts_i.len_ok ? ST_PAYLOAD : ST_IDLE;
      end
      ST_PAYLOAD: begin
        // zero length lands here with nothing left: the next byte aborts
        if (rx_xfer) begin
          if (!sts_i.rem_nz) state_d = ST_IDLE;
          else if (sts_i.rem_one) state_d = ST_CHECKSUM;
        end
      end
      ST_CHECKSUM: begin
        if (rx_xfer) state_d = sts_i.sum_ok ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (rec_ready_i) state_d = sts_i.rec_last ? ST_IDLE : ST_READ;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rec_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.sum_init = rx_xfer;
      end
      ST_GOT_FF, ST_GOT_FC: begin
        cmd_o.sum_add = rx_xfer;
      end
      ST_GOT_CMD: begin
        cmd_o.sum_add  = rx_xfer;
        cmd_o.len_load = rx_xfer;
      end
      ST_PAYLOAD: begin
        cmd_o.sum_add   = rx_xfer & sts_i.rem_nz;
        cmd_o.pay_write = rx_xfer & sts_i.rem_nz;
      end
      ST_CHECKSUM: begin
        cmd_o.csum_save = rx_xfer;
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
      end
      ST_SEND: begin
        rec_valid_o   = 1'b1;
        cmd_o.idx_inc = rec_ready_i & ~sts_i.rec_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> rtl/cfr_dp.sv
module cfr_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [cfr_pkg::BYTE_W-1:0]          rx_byte_i,
  input  cfr_pkg::cfr_cmd_t                   cmd_i,
  output cfr_pkg::cfr_sts_t                   sts_o,
  output logic                                record_kind_o,
  output logic [cfr_pkg::IDX_W-1:0]           pair_index_o,
  output logic [cfr_pkg::IDX_W-1:0]           pair_count_o,
  output logic [cfr_pkg::BYTE_W-1:0]          value_a_o,
  output logic [cfr_pkg::BYTE_W-1:0]          value_b_o,
  output logic                                last_o
);
  import cfr_pkg::*;

  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [LEN_W-1:0]  remain_q, remain_d;
  logic [LEN_W-1:0]  bcount_q, bcount_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              len_one_q, len_one_d;
  logic [BYTE_W-1:0] csum_q;
  logic [BYTE_W-1:0] rd_a_q, rd_b_q;
  logic [LEN_W-1:0]  len_in;

  logic [BYTE_W-1:0] mem [PAYLOAD_DEPTH];

  assign len_in = rx_byte_i[LEN_W-1:0];

  always_comb begin
    sum_d     = sum_q;
    remain_d  = remain_q;
    bcount_d  = bcount_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    len_one_d = len_one_q;
    if (cmd_i.sum_init) sum_d = rx_byte_i;
    if (cmd_i.sum_add)  sum_d = sum_q + rx_byte_i;
    if (cmd_i.len_load) begin
      remain_d  = len_in;
      bcount_d  = '0;
      len_one_d = (len_in == LEN_W'(1));
      // pairs = (len - 2) / 2, zero for lengths below two
      cnt_d     = (len_in >= LEN_W'(2)) ? IDX_W'((len_in - LEN_W'(2)) >> 1) : '0;
    end
    if (cmd_i.pay_write) begin
      remain_d = remain_q - LEN_W'(1);
      bcount_d = bcount_q + LEN_W'(1);
    end
    if (cmd_i.csum_save) idx_d = '0;
    if (cmd_i.idx_inc)   idx_d = idx_q + IDX_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      remain_q  <= '0;
      bcount_q  <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      len_one_q <= 1'b0;
    end else begin
      sum_q     <= sum_d;
      remain_q  <= remain_d;
      bcount_q  <= bcount_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      len_one_q <= len_one_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.csum_save) csum_q <= rx_byte_i;
  end

  // payload store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.pay_write) mem[ADDR_W'(bcount_q)] <= rx_byte_i;
    if (cmd_i.rd_issue) begin
      rd_a_q <= mem[ADDR_W'({idx_q, 1'b0})];
      rd_b_q <= mem[ADDR_W'({idx_q, 1'b1})];
    end
  end

  always_comb begin
    sts_o.hdr_first  = (rx_byte_i == HDR_FIRST);
    sts_o.hdr_second = (rx_byte_i == HDR_SECOND);
    sts_o.cmd_ok     = (rx_byte_i < CMD_LIMIT);
    sts_o.len_ok     = (rx_byte_i < LEN_LIMIT);
    sts_o.rem_nz     = (remain_q != '0);
    sts_o.rem_one    = (remain_q == LEN_W'(1));
    sts_o.sum_ok     = (sum_q == rx_byte_i);
    sts_o.rec_last   = (idx_q == cnt_q);
  end

  assign last_o        = (idx_q == cnt_q);
  assign record_kind_o = last_o ? REC_REGION : REC_PAIR;
  assign pair_index_o  = idx_q;
  assign pair_count_o  = cnt_q;
  assign value_a_o     = rd_a_q;
  // a one-byte payload takes region B from the checksum byte
  assign value_b_o     = (last_o && len_one_q) ? csum_q : rd_b_q;

endmodule

>>> rtl/checksummed_frame_receiver.sv
// Parser takes one byte per cycle while receiving a frame; no result for header/payload bytes.
// After a good checksum byte, each record is made by a registered payload-store read (ST_READ),
// then held in ST_SEND until transfer; up to 24 records.
// rx_i.ready is low while records of a frame are being sent.
// Reset (rst_ni, async active low) returns the parser to idle and clears counters and sum;
// the payload store is not cleared.
module checksummed_frame_receiver (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfr_in_if.sink    rx_i,
  cfr_out_if.source rec_o
);
  import cfr_pkg::*;

  cfr_cmd_t cmd;
  cfr_sts_t sts;

  cfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_i.valid),
    .rec_ready_i (rec_o.ready),
    .sts_i       (sts),
    .rx_ready_o  (rx_i.ready),
    .rec_valid_o (rec_o.valid),
    .cmd_o       (cmd)
  );

  cfr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_i.rx_byte),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .record_kind_o (rec_o.record_kind),
    .pair_index_o  (rec_o.pair_index),
    .pair_count_o  (rec_o.pair_count),
    .value_a_o     (rec_o.value_a),
    .value_b_o     (rec_o.value_b),
    .last_o        (rec_o.last)
  );

endmodule

>>> rtl/cfr_checker.sv
module cfr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rx_ready_i,
  input logic                         rec_valid_i,
  input logic                         rec_ready_i,
  input logic                         record_kind_i,
  input logic [cfr_pkg::IDX_W-1:0]    pair_index_i,
  input logic [cfr_pkg::IDX_W-1:0]    pair_count_i,
  input logic [cfr_pkg::BYTE_W-1:0]   value_a_i,
  input logic [cfr_pkg::BYTE_W-1:0]   value_b_i,
  input logic                         last_i
);
  import cfr_pkg::*;

  // a held record keeps its contents
  a_rec_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_i && !rec_ready_i |=> rec_valid_i && $stable(pair_index_i)
      && $stable(value_a_i) && $stable(value_b_i) && $stable(last_i))
    else $error("record changed while stalled");

  // byte intake is paused during a record burst
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rec_valid_i && rx_ready_i))
    else $error("input ready while records pending");

  a_region_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_i |-> (last_i == record_kind_i)
      && (last_i ? (pair_index_i == pair_count_i) : (pair_index_i < pair_count_i)))
    else $error("record index or kind inconsistent");

  a_burst_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_i && rec_ready_i && last_i |=> !rec_valid_i)
    else $error("record after region record");

  a_burst_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_i && rec_ready_i && !last_i |=> !rec_valid_i ##1
      (rec_valid_i && pair_index_i == $past(pair_index_i, 2) + IDX_W'(1)))
    else $error("pair index did not advance by one");

endmodule

bind checksummed_frame_receiver cfr_checker u_cfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rx_ready_i    (rx_i.ready),
  .rec_valid_i   (rec_o.valid),
  .rec_ready_i   (rec_o.ready),
  .record_kind_i (rec_o.record_kind),
  .pair_index_i  (rec_o.pair_index),
  .pair_count_i  (rec_o.pair_count),
  .value_a_i     (rec_o.value_a),
  .value_b_i     (rec_o.value_b),
  .last_i        (rec_o.last)
);

>>> tb/frame_record_checker.sv
`timescale 1ns / 100ps

module frame_record_checker (
  input  logic clk_i,
  input  logic rst_ni,
  cfr_in_if    rx,
  cfr_out_if   rec,
  output int   fail_count_o,
  output int   pending_o
);
  import cfr_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  cnt;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic              last;
  } frame_rec_t;

  cfr_state_e        phase;
  logic [LEN_W-1:0]  bytes_left;
  logic [LEN_W-1:0]  bytes_seen;
  logic [LEN_W-1:0]  frame_len;
  logic [BYTE_W-1:0] frame_sum;
  logic [BYTE_W-1:0] payload_mem [PAYLOAD_DEPTH];
  frame_rec_t        records_due [$];

  // Advance the frame parser by one byte; queue the records a good checksum releases.
  task automatic parse_byte(input logic [BYTE_W-1:0] b);
    logic [IDX_W-1:0]  pairs;
    logic [BYTE_W-1:0] reg_b;
    case (phase)
      ST_IDLE: begin
        if (b == HDR_FIRST) begin
          phase     = ST_GOT_FF;
          frame_sum = b;
        end
      end
      ST_GOT_FF: begin
        if (b == HDR_SECOND) begin
          phase     = ST_GOT_FC;
          frame_sum = frame_sum + b;
        end else begin
          phase = ST_IDLE;
        end
      end
      ST_GOT_FC: begin
        if (b < CMD_LIMIT) begin
          phase     = ST_GOT_CMD;
          frame_sum = frame_sum + b;
        end else begin
          phase = ST_IDLE;
        end
      end
      ST_GOT_CMD: begin
        if (b < LEN_LIMIT) begin
          phase      = ST_PAYLOAD;
          frame_sum  = frame_sum + b;
          frame_len  = b[LEN_W-1:0];
          bytes_left = b[LEN_W-1:0];
          bytes_seen = '0;
        end else begin
          phase = ST_IDLE;
        end
      end
      ST_PAYLOAD: begin
        // zero length lands here with nothing left: the frame is dropped
        if (bytes_left != 0) begin
          payload_mem[bytes_seen] = b;
          bytes_seen = bytes_seen + 1'b1;
          bytes_left = bytes_left - 1'b1;
          frame_sum  = frame_sum + b;
          if (bytes_left == 0) phase = ST_CHECKSUM;
        end else begin
          phase = ST_IDLE;
        end
      end
      ST_CHECKSUM: begin
        phase = ST_IDLE;
        if (frame_sum == b) begin
          pairs = (frame_len >= 2) ? IDX_W'((frame_len - 2) >> 1) : '0;
          for (int i = 0; i < pairs; i++) begin
            records_due.push_back('{REC_PAIR, IDX_W'(i), pairs,
                                    payload_mem[LEN_W'(2 * i)],
                                    payload_mem[LEN_W'(2 * i + 1)], 1'b0});
          end
          // single-byte payload: region B is the checksum byte itself
          reg_b = ({1'b0, pairs, 1'b1} < {1'b0, frame_len}) ? payload_mem[{pairs, 1'b1}] : b;
          records_due.push_back('{REC_REGION, pairs, pairs, payload_mem[{pairs, 1'b0}],
                                  reg_b, 1'b1});
        end
      end
      default: phase = ST_IDLE;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_rec_t got;
    frame_rec_t want;
    if (!rst_ni) begin
      phase        = ST_IDLE;
      bytes_left   = '0;
      bytes_seen   = '0;
      frame_len    = '0;
      frame_sum    = '0;
      records_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (rx.valid && rx.ready) parse_byte(rx.rx_byte);
      if (rec.valid && rec.ready) begin
        got = '{rec.record_kind, rec.pair_index, rec.pair_count,
                rec.value_a, rec.value_b, rec.last};
        if (records_due.size() == 0) begin
          if (fail_count_o < 10)
            $display({"%0t: unexpected record kind=%0d idx=%0d cnt=%0d",
                      " a=%02h b=%02h last=%0d"},
                     $realtime, got.kind, got.idx, got.cnt, got.a, got.b, got.last);
          fail_count_o++;
        end else begin
          want = records_due.pop_front();
          if (got.kind !== want.kind || got.idx !== want.idx || got.cnt !== want.cnt ||
              got.a !== want.a || got.b !== want.b || got.last !== want.last) begin
            if (fail_count_o < 10) begin
              $display({"%0t: record mismatch, expected kind=%0d idx=%0d cnt=%0d",
                        " a=%02h b=%02h last=%0d"},
                       $realtime, want.kind, want.idx, want.cnt, want.a, want.b, want.last);
              $display({"%0t:                    actual kind=%0d idx=%0d cnt=%0d",
                        " a=%02h b=%02h last=%0d"},
                       $realtime, got.kind, got.idx, got.cnt, got.a, got.b, got.last);
            end
            fail_count_o++;
          end
        end
      end
      pending_o = records_due.size();
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import cfr_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum int {FR_GOOD, FR_BAD_SUM, FR_CUT, FR_HIT} frame_flaw_e;

  localparam int HOLD_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  cfr_in_if  rx_if ();
  cfr_out_if rec_if ();

  int fail_count;
  int pending;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit hold_req     = 1'b0;
  int bytes_sent   = 0;

  // header mismatch, command 0xFF, length 50, zero length, length one, length two
  logic [BYTE_W-1:0] directed_bytes [28] = '{
    HDR_FIRST, HDR_FIRST, HDR_SECOND,
    HDR_FIRST, HDR_SECOND, CMD_LIMIT,
    HDR_FIRST, HDR_SECOND, 8'h05, LEN_LIMIT,
    HDR_FIRST, HDR_SECOND, 8'h01, 8'h00, HDR_FIRST,
    HDR_FIRST, HDR_SECOND, 8'h00, 8'h01, 8'h00, 8'hFC,
    HDR_FIRST, HDR_SECOND, 8'hFE, 8'h02, 8'hFF, 8'hFF, 8'hF9
  };

  checksummed_frame_receiver dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .rec_o  (rec_if)
  );

  frame_record_checker rec_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx           (rx_if),
    .rec          (rec_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

  // record sink: random stalls, or a long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        rec_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        rec_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        @(posedge clk_i);
      end
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    tx_idle_pct  = (mode == IDLE_SENDER)   ? 71 : (mode == IDLE_BOTH) ? 22 : 0;
    rx_stall_pct = (mode == IDLE_RECEIVER) ? 71 : (mode == IDLE_BOTH) ? 22 : 0;
  endtask

  task automatic put_byte(input logic [BYTE_W-1:0] b);
    bit took;
    while ($urandom_range(99) < tx_idle_pct) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= BYTE_W'($urandom);
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    // ready is settled by the falling edge; the transfer happens on the next rising one
    do begin
      @(negedge clk_i);
      took = rx_if.ready;
      @(posedge clk_i);
    end while (!took);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] cmd, input int len,
                            input frame_flaw_e flaw);
    logic [BYTE_W-1:0] seq [$];
    logic [BYTE_W-1:0] sum;
    int                cut;
    seq.push_back(HDR_FIRST);
    seq.push_back(HDR_SECOND);
    seq.push_back(cmd);
    seq.push_back(BYTE_W'(len));
    repeat (len) seq.push_back(BYTE_W'($urandom));
    sum = '0;
    foreach (seq[i]) sum += seq[i];
    seq.push_back(sum);
    case (flaw)
      FR_BAD_SUM: seq[seq.size() - 1] ^= BYTE_W'($urandom_range(1, 255));
      FR_CUT: begin
        cut = $urandom_range(1, seq.size() - 1);
        repeat (cut) void'(seq.pop_back());
      end
      FR_HIT: seq[$urandom_range(seq.size() - 1)] ^= BYTE_W'($urandom_range(1, 255));
      default: ;
    endcase
    foreach (seq[i]) put_byte(seq[i]);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (pending != 0);
  endtask

  initial begin
    int pick;
    int len;
    int phase_end;
    rst_ni        <= 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(IDLE_NONE);
    foreach (directed_bytes[i]) put_byte(directed_bytes[i]);

    // largest frame against a held-off sink, another frame queued behind it
    hold_req = 1'b1;
    send_frame(BYTE_W'($urandom_range(254)), 49, FR_GOOD);
    send_frame(BYTE_W'($urandom_range(254)), 4, FR_GOOD);
    rx_if.valid <= 1'b0;
    wait_drained();
    @(posedge clk_i);

    // one stretch of random traffic per idling pattern
    for (int m = 0; m < 4; m++) begin
      set_idling(idle_mode_e'(m));
      phase_end = bytes_sent + 10;
      while (bytes_sent < phase_end) begin
        pick = $urandom_range(99);
        len  = $urandom_range(0, 12);
        if (pick < 60)      send_frame(BYTE_W'($urandom_range(254)), len, FR_GOOD);
        else if (pick < 70) send_frame(BYTE_W'($urandom_range(254)), len, FR_BAD_SUM);
        else if (pick < 80) send_frame(BYTE_W'($urandom_range(254)), len, FR_CUT);
        else if (pick < 88) send_frame(BYTE_W'($urandom), len, FR_HIT);
        else begin
          repeat ($urandom_range(1, 4))
            put_byte(($urandom_range(3) == 0) ? HDR_FIRST : BYTE_W'($urandom));
        end
      end
    end
    rx_if.valid <= 1'b0;

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
